// ----- hdl/berld_pkg.sv -----
`default_nettype none
package berld_pkg;

  // widest length field accepted by default
  localparam int LEN_BYTES_DEF = 8;

  // result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_TOOLONG = 2'd2;

  // header byte fields
  localparam logic [7:0] HDR_LONG_FORM = 8'h80;
  localparam logic [7:0] HDR_LEN_MASK  = 8'h7f;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } berld_result_t;

endpackage
`default_nettype wire

// ----- hdl/berld_decode.sv -----
`default_nettype none
module berld_decode #(
  parameter int LEN_BYTES = berld_pkg::LEN_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_fire,
  input  wire logic [7:0]            in_byte,
  output berld_pkg::berld_result_t   res
);
  import berld_pkg::*;

  localparam int CNT_W = 8 * LEN_BYTES;
  localparam int LBL_W = $clog2(LEN_BYTES + 1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [LBL_W-1:0]   lbl_r, lbl_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   cnt_shift, cnt_dec;
  logic [LBL_W-1:0]   lbl_dec;
  logic [6:0]         hdr_n;

  assign cnt_shift = (cnt_r << 8) | CNT_W'(in_byte);
  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign lbl_dec   = lbl_r - LBL_W'(1);
  assign hdr_n     = 7'(in_byte & HDR_LEN_MASK);

  always_comb begin
    phase_nxt = phase_r;
    lbl_nxt   = lbl_r;
    cnt_nxt   = cnt_r;
    res       = '0;
    case (phase_r)
      PH_LENGTH: begin
        cnt_nxt = cnt_shift;
        lbl_nxt = lbl_dec;
        if (lbl_dec == '0) begin
          if (cnt_shift == '0) begin
            phase_nxt = PH_HEADER;
            res.valid = 1'b1;
            res.kind  = KIND_EMPTY;
            res.last  = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        cnt_nxt   = cnt_dec;
        res.valid = 1'b1;
        res.kind  = KIND_DATA;
        res.data  = in_byte;
        if (cnt_dec == '0) begin
          phase_nxt = PH_HEADER;
          res.last  = 1'b1;
        end
      end
      default: begin
        // header byte, also recovers from the unused phase code
        phase_nxt = PH_HEADER;
        lbl_nxt   = '0;
        cnt_nxt   = '0;
        if ((in_byte & HDR_LONG_FORM) == 8'h00) begin
          if (in_byte == 8'h00) begin
            res.valid = 1'b1;
            res.kind  = KIND_EMPTY;
            res.last  = 1'b1;
          end else begin
            cnt_nxt   = CNT_W'(in_byte);
            phase_nxt = PH_PAYLOAD;
          end
        end else if (hdr_n > 7'(LEN_BYTES)) begin
          res.valid = 1'b1;
          res.kind  = KIND_TOOLONG;
        end else if (hdr_n == 7'd0) begin
          res.valid = 1'b1;
          res.kind  = KIND_EMPTY;
          res.last  = 1'b1;
        end else begin
          lbl_nxt   = LBL_W'(hdr_n);
          phase_nxt = PH_LENGTH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      lbl_r   <= '0;
      cnt_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      lbl_r   <= lbl_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/berld_outreg.sv -----
`default_nettype none
module berld_outreg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire berld_pkg::berld_result_t res,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_byte,
  output logic                       out_last
);
  import berld_pkg::*;

  logic          valid_r, valid_nxt;
  berld_result_t res_r;

  // a new beat replaces the held one; otherwise a taken beat empties the slot
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res.valid;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load && res.valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = res_r.kind;
  assign out_byte  = res_r.data;
  assign out_last  = res_r.last;

endmodule
`default_nettype wire

// ----- hdl/ber_length_deframer.sv -----
// ber_length_deframer: splits a stream of length-prefixed messages into beats
// input channel: one stream byte per beat (in_valid / in_stall / in_byte),
//   header bytes in short form (below 0x80) or long form (0x80 + n, then n
//   big-endian length bytes), followed by that many payload bytes
// output channel: at most one beat per input beat (out_valid / out_stall)
//   out_kind data with the payload byte in out_byte and out_last on the
//   final byte, empty for a zero-length message (out_last set), or too long
//   when n exceeds LEN_BYTES; header and length bytes otherwise give nothing
// timing: a result is registered in the cycle after the input beat causing it
// throughput: one input beat per cycle while in_stall is low; the header
//   decode, length shift and payload count decrement are all combinational
//   ahead of the output register
// stall: the output register holds its beat while out_stall is high; the
//   input is stalled only while that register is full and stalled, so a
//   taken beat is replaced in the same cycle
// reset: rst_n low empties the output register and returns the deframer
//   to waiting for a header with a cleared count
`default_nettype none
module ber_length_deframer #(
  parameter int LEN_BYTES = berld_pkg::LEN_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import berld_pkg::*;

  logic          in_fire;
  berld_result_t res;

  // the only back-pressure: a full output register that is not being taken
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // header, length and payload tracking
  berld_decode #(
    .LEN_BYTES (LEN_BYTES)
  ) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_byte),
    .res     (res)
  );

  // result register towards the receiver
  berld_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // only payload beats carry a byte
  a_byte_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> (out_byte == 8'h00))
    else $error("non-data beat carries a byte");

  // an empty message always ends the message, an error never does
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_EMPTY) |-> out_last)
    else $error("empty message beat without last");

  a_toolong_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_TOOLONG) |-> !out_last)
    else $error("length error beat marked last");

  // the spare kind code never leaves the block
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_EMPTY ||
                   out_kind == KIND_TOOLONG))
    else $error("illegal result kind");

  // the input is never stalled while the output register is empty
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

endmodule
`default_nettype wire
